@@ sv/two_link_inverse_kinematics_defines.svh @@
// Assertion macros for the two-link inverse kinematics block.
// Included by RTL files that carry concurrent checks; define ASSERT_OFF to drop them.
`ifndef TWO_LINK_INVERSE_KINEMATICS_DEFINES_SVH
`define TWO_LINK_INVERSE_KINEMATICS_DEFINES_SVH
`ifndef ASSERT_OFF
`define IKL_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
`define IKL_ASSERT_NR(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define IKL_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define IKL_ASSERT_NR(lbl, clk_s, prop, msg)
`endif
`endif

@@ sv/ikl_pkg.sv @@
// Shared types and constants for the two-link inverse kinematics pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package ikl_pkg;
  localparam int ZW = 26;           // CORDIC angle, 2^-16 degree
  localparam int CW = 50;           // CORDIC vector datapath
  localparam int QW = 31;           // cosine magnitude / divider quotient
  localparam int BASE_LIM = 46080;
  localparam int ELBOW_LIM = 23040;
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(11796480);
  localparam logic [14:0] UPPER_RESET = 15'd2304;
  localparam logic [14:0] LOWER_RESET = 15'd1894;
  localparam logic [QW-1:0] Q_ONE = QW'(1) << 30;

  typedef enum logic [0:0] {
    REG_UPPER_LINK = 1'b0,
    REG_LOWER_LINK = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic               neg;
    logic               oor;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } div_side_t;

  typedef struct packed {
    logic               oor;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [31:0] c;
  } sqrt_side_t;

  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = ZW'(2949120);
      1:  a = ZW'(1740967);
      2:  a = ZW'(919879);
      3:  a = ZW'(466945);
      4:  a = ZW'(234379);
      5:  a = ZW'(117304);
      6:  a = ZW'(58666);
      7:  a = ZW'(29335);
      8:  a = ZW'(14668);
      9:  a = ZW'(7334);
      10: a = ZW'(3667);
      11: a = ZW'(1833);
      12: a = ZW'(917);
      13: a = ZW'(458);
      14: a = ZW'(229);
      15: a = ZW'(115);
      16: a = ZW'(57);
      17: a = ZW'(29);
      18: a = ZW'(14);
      19: a = ZW'(7);
      20: a = ZW'(4);
      21: a = ZW'(2);
      22: a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction
endpackage
`default_nettype wire

@@ sv/ikl_in_if.sv @@
// Target point channel: valid/ready handshake with signed Q8.8 coordinates.
// No dependencies.
`default_nettype none
interface ikl_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  modport source (output valid, target_x, target_y, input ready);
  modport sink (input valid, target_x, target_y, output ready);
endinterface
`default_nettype wire

@@ sv/ikl_out_if.sv @@
// Joint angle channel: valid/ready handshake with angles in 1/128 degree.
// No dependencies.
`default_nettype none
interface ikl_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] base_angle;
  logic        [14:0] elbow_angle;
  logic               out_of_reach;
  modport source (output valid, base_angle, elbow_angle, out_of_reach, input ready);
  modport sink (input valid, base_angle, elbow_angle, out_of_reach, output ready);
endinterface
`default_nettype wire

@@ sv/ikl_div_cell.sv @@
// One restoring-division cell: resolves one quotient bit per beat.
// Depends on ikl_pkg.
`default_nettype none
module ikl_div_cell import ikl_pkg::*; #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [QW-1:0] den,
  input  logic          valid_in,
  input  logic [QW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  input  logic [QW-1:0] quot_in,
  input  logic [SW-1:0] side_in,
  output logic          valid_out,
  output logic [QW-1:0] rem_out,
  output logic [QW-1:0] low_out,
  output logic [QW-1:0] quot_out,
  output logic [SW-1:0] side_out
);
  logic [QW:0]   trial;
  logic [QW:0]   diff;
  logic          ge;
  logic [QW-1:0] rem_nxt;
  logic          valid_r;
  logic [QW-1:0] rem_r;
  logic [QW-1:0] low_r;
  logic [QW-1:0] quot_r;
  logic [SW-1:0] side_r;

  assign trial   = {rem_in, low_in[QW-1]};
  assign diff    = trial - {1'b0, den};
  assign ge      = trial >= {1'b0, den};
  assign rem_nxt = ge ? diff[QW-1:0] : trial[QW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      low_r  <= {low_in[QW-2:0], 1'b0};
      quot_r <= {quot_in[QW-2:0], ge};
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign rem_out   = rem_r;
  assign low_out   = low_r;
  assign quot_out  = quot_r;
  assign side_out  = side_r;
endmodule
`default_nettype wire

@@ sv/ikl_sqrt_cell.sv @@
// One digit of the bitwise integer square root (two radicand bits per beat).
// Depends on ikl_pkg.
`default_nettype none
module ikl_sqrt_cell import ikl_pkg::*; #(
  parameter int B  = 60,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          valid_in,
  input  logic [61:0]   v_in,
  input  logic [61:0]   r_in,
  input  logic [SW-1:0] side_in,
  output logic          valid_out,
  output logic [61:0]   v_out,
  output logic [61:0]   r_out,
  output logic [SW-1:0] side_out
);
  localparam logic [61:0] BIT = 62'(1) << B;

  logic [61:0]   rb;
  logic          ge;
  logic [61:0]   v_nxt;
  logic [61:0]   r_nxt;
  logic          valid_r;
  logic [61:0]   v_r;
  logic [61:0]   r_r;
  logic [SW-1:0] side_r;

  assign rb    = r_in + BIT;
  assign ge    = v_in >= rb;
  assign v_nxt = ge ? v_in - rb : v_in;
  assign r_nxt = ge ? (r_in >> 1) + BIT : r_in >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= v_nxt;
      r_r    <= r_nxt;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign v_out     = v_r;
  assign r_out     = r_r;
  assign side_out  = side_r;
endmodule
`default_nettype wire

@@ sv/ikl_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation with a fixed shift of I.
// Depends on ikl_pkg (arctangent table).
`default_nettype none
module ikl_cordic_cell import ikl_pkg::*; #(
  parameter int I  = 0,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_in,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  logic                 zero_in,
  input  logic [SW-1:0]        side_in,
  output logic                 valid_out,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output logic                 zero_out,
  output logic [SW-1:0]        side_out
);
  localparam logic signed [ZW-1:0] ANG = atan_step(I);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] x_nxt;
  logic signed [CW-1:0] y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic                 valid_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  logic                 zero_r;
  logic [SW-1:0]        side_r;

  assign xs = x_in >>> I;
  assign ys = y_in >>> I;

  always_comb begin
    if (!y_in[CW-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ANG;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_in;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign z_out     = z_r;
  assign zero_out  = zero_r;
  assign side_out  = side_r;
endmodule
`default_nettype wire

@@ sv/ikl_cordic.sv @@
// atan2 lane: half-plane fold stage followed by a row of CORDIC cells.
// Depends on ikl_pkg and ikl_cordic_cell.
`default_nettype none
module ikl_cordic import ikl_pkg::*; #(
  parameter int STEPS = 16,
  parameter int SW    = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_in,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic [SW-1:0]        side_in,
  output logic                 valid_out,
  output logic signed [ZW-1:0] z_out,
  output logic [SW-1:0]        side_out
);
  logic                 cv    [0:STEPS];
  logic signed [CW-1:0] cx    [0:STEPS];
  logic signed [CW-1:0] cy    [0:STEPS];
  logic signed [ZW-1:0] cz    [0:STEPS];
  logic                 czero [0:STEPS];
  logic [SW-1:0]        cs    [0:STEPS];

  logic                 neg;
  logic signed [CW-1:0] x_nxt;
  logic signed [CW-1:0] y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic                 zero_nxt;
  logic                 valid_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  logic                 zero_r;
  logic [SW-1:0]        side_r;

  // left half-plane: flip the vector and start from +/-180 degrees
  assign neg      = x_in[CW-1];
  assign zero_nxt = (x_in == '0) && (y_in == '0);
  assign x_nxt    = neg ? -x_in : x_in;
  assign y_nxt    = neg ? -y_in : y_in;
  assign z_nxt    = !neg ? '0 : (y_in[CW-1] ? -HALF_TURN : HALF_TURN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      zero_r <= zero_nxt;
      side_r <= side_in;
    end
  end

  assign cv[0]    = valid_r;
  assign cx[0]    = x_r;
  assign cy[0]    = y_r;
  assign cz[0]    = z_r;
  assign czero[0] = zero_r;
  assign cs[0]    = side_r;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    ikl_cordic_cell #(.I(i), .SW(SW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .valid_in  (cv[i]),
      .x_in      (cx[i]),
      .y_in      (cy[i]),
      .z_in      (cz[i]),
      .zero_in   (czero[i]),
      .side_in   (cs[i]),
      .valid_out (cv[i+1]),
      .x_out     (cx[i+1]),
      .y_out     (cy[i+1]),
      .z_out     (cz[i+1]),
      .zero_out  (czero[i+1]),
      .side_out  (cs[i+1])
    );
  end

  assign valid_out = cv[STEPS];
  assign z_out     = czero[STEPS] ? '0 : cz[STEPS];
  assign side_out  = cs[STEPS];
endmodule
`default_nettype wire

@@ sv/two_link_inverse_kinematics.sv @@
// Two-link planar arm inverse kinematics, fully pipelined: one beat per cycle.
// The pipe holds 31 divider cells for the cosine, 31 square-root cells for the
// sine and CORDIC_STEPS cells per atan2 lane.
// The whole pipe stalls only while the output register holds an untaken beat.
// Synchronous active-low reset clears all valid bits and restores link lengths.
`default_nettype none
`include "two_link_inverse_kinematics_defines.svh"
module two_link_inverse_kinematics import ikl_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ikl_in_if.sink      in_ch,
  ikl_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [14:0] cfg_data
);
  localparam int DIV_CELLS  = QW;
  localparam int SQRT_CELLS = 31;
  localparam int DSW = $bits(div_side_t);
  localparam int SSW = $bits(sqrt_side_t);
  localparam logic signed [ZW:0] BASE_HI  = (ZW+1)'(BASE_LIM);
  localparam logic signed [ZW:0] BASE_LO  = -BASE_HI;
  localparam logic signed [ZW:0] ELBOW_HI = (ZW+1)'(ELBOW_LIM);
  localparam logic signed [ZW:0] ROUND    = (ZW+1)'(256);

  logic en;

  // link length registers and values derived from them
  logic [14:0] upper_r;
  logic [14:0] lower_r;
  logic [15:0] sum_len;
  logic [14:0] dif_len;
  logic [31:0] sum_sq;
  logic [29:0] dif_sq;
  logic [29:0] up_sq;
  logic [29:0] lo_sq;
  logic [29:0] up_lo;
  logic [31:0] reach_hi_r;
  logic [29:0] reach_lo_r;
  logic [30:0] lsq_r;
  logic [QW-1:0] den_r;
  logic        link_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= UPPER_RESET;
      lower_r <= LOWER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_UPPER_LINK: upper_r <= cfg_data;
        REG_LOWER_LINK: lower_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sum_len = {1'b0, upper_r} + {1'b0, lower_r};
  assign dif_len = (upper_r >= lower_r) ? upper_r - lower_r : lower_r - upper_r;
  assign sum_sq  = sum_len * sum_len;
  assign dif_sq  = dif_len * dif_len;
  assign up_sq   = upper_r * upper_r;
  assign lo_sq   = lower_r * lower_r;
  assign up_lo   = upper_r * lower_r;

  always_ff @(posedge clk) begin
    reach_hi_r  <= sum_sq;
    reach_lo_r  <= dif_sq;
    lsq_r       <= {1'b0, up_sq} + {1'b0, lo_sq};
    den_r       <= {up_lo, 1'b0};
    link_zero_r <= (upper_r == '0) || (lower_r == '0);
  end

  // stage A: input register
  logic               a_v_r;
  logic signed [15:0] a_x_r;
  logic signed [15:0] a_y_r;

  // stage B: squared distance
  logic signed [31:0] x_sq;
  logic signed [31:0] y_sq;
  logic [31:0]        d2_nxt;
  logic               b_v_r;
  logic [31:0]        b_d2_r;
  logic signed [15:0] b_x_r;
  logic signed [15:0] b_y_r;

  // stage C: reach test and cosine numerator magnitude
  logic signed [32:0] num;
  logic [32:0]        num_abs;
  logic               oor_nxt;
  logic               c_v_r;
  logic [31:0]        c_mag_r;
  div_side_t          c_side_r;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  assign x_sq    = a_x_r * a_x_r;
  assign y_sq    = a_y_r * a_y_r;
  assign d2_nxt  = x_sq + y_sq;
  assign num     = $signed({2'b0, lsq_r}) - $signed({1'b0, b_d2_r});
  assign num_abs = num[32] ? -num : num;
  assign oor_nxt = link_zero_r || (b_d2_r > reach_hi_r) || (b_d2_r < {2'b0, reach_lo_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_ch.valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r          <= in_ch.target_x;
      a_y_r          <= in_ch.target_y;
      b_d2_r         <= d2_nxt;
      b_x_r          <= a_x_r;
      b_y_r          <= a_y_r;
      c_mag_r        <= num_abs[31:0];
      c_side_r.neg   <= num[32];
      c_side_r.oor   <= oor_nxt;
      c_side_r.x     <= b_x_r;
      c_side_r.y     <= b_y_r;
    end
  end

  // divider row: dividend is mag * 2^30 + den / 2, rounded quotient
  logic          dv    [0:DIV_CELLS];
  logic [QW-1:0] drem  [0:DIV_CELLS];
  logic [QW-1:0] dlow  [0:DIV_CELLS];
  logic [QW-1:0] dquot [0:DIV_CELLS];
  logic [DSW-1:0] dside [0:DIV_CELLS];

  assign dv[0]    = c_v_r;
  assign drem[0]  = c_mag_r[31:1];
  assign dlow[0]  = {c_mag_r[0], den_r[QW-1:1]};
  assign dquot[0] = '0;
  assign dside[0] = c_side_r;

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    ikl_div_cell #(.SW(DSW)) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .den       (den_r),
      .valid_in  (dv[i]),
      .rem_in    (drem[i]),
      .low_in    (dlow[i]),
      .quot_in   (dquot[i]),
      .side_in   (dside[i]),
      .valid_out (dv[i+1]),
      .rem_out   (drem[i+1]),
      .low_out   (dlow[i+1]),
      .quot_out  (dquot[i+1]),
      .side_out  (dside[i+1])
    );
  end

  // stages E, F, G: clamp cosine, square it, form 1 - c^2
  div_side_t     d_side;
  logic [QW-1:0] q_cl;
  logic          e_v_r;
  logic [QW-1:0] e_q_r;
  sqrt_side_t    e_side_r;
  logic          f_v_r;
  logic [61:0]   f_qsq_r;
  sqrt_side_t    f_side_r;
  logic          g_v_r;
  logic [61:0]   g_rad_r;
  sqrt_side_t    g_side_r;

  assign d_side = dside[DIV_CELLS];
  assign q_cl   = (dquot[DIV_CELLS] > Q_ONE) ? Q_ONE : dquot[DIV_CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= dv[DIV_CELLS];
      f_v_r <= e_v_r;
      g_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_q_r        <= q_cl;
      e_side_r.oor <= d_side.oor;
      e_side_r.x   <= d_side.x;
      e_side_r.y   <= d_side.y;
      e_side_r.c   <= d_side.neg ? -$signed({1'b0, q_cl}) : $signed({1'b0, q_cl});
      f_qsq_r      <= e_q_r * e_q_r;
      f_side_r     <= e_side_r;
      g_rad_r      <= (62'(1) << 60) - f_qsq_r;
      g_side_r     <= f_side_r;
    end
  end

  // square-root row: sine = floor(sqrt(2^60 - c^2))
  logic           sv    [0:SQRT_CELLS];
  logic [61:0]    srad  [0:SQRT_CELLS];
  logic [61:0]    sroot [0:SQRT_CELLS];
  logic [SSW-1:0] sside [0:SQRT_CELLS];

  assign sv[0]    = g_v_r;
  assign srad[0]  = g_rad_r;
  assign sroot[0] = '0;
  assign sside[0] = g_side_r;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    ikl_sqrt_cell #(.B(60 - 2 * k), .SW(SSW)) u_sqrt (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .valid_in  (sv[k]),
      .v_in      (srad[k]),
      .r_in      (sroot[k]),
      .side_in   (sside[k]),
      .valid_out (sv[k+1]),
      .v_out     (srad[k+1]),
      .r_out     (sroot[k+1]),
      .side_out  (sside[k+1])
    );
  end

  // stage H: second-link vector k1 = L1 + L2*cos, k2 = L2*sin
  sqrt_side_t         s_side;
  logic [30:0]        s_val;
  logic signed [47:0] l2c;
  logic               h_v_r;
  logic signed [47:0] h_k1_r;
  logic [45:0]        h_k2_r;
  logic [30:0]        h_s_r;
  logic signed [31:0] h_c_r;
  logic signed [15:0] h_x_r;
  logic signed [15:0] h_y_r;
  logic               h_oor_r;

  assign s_side = sside[SQRT_CELLS];
  assign s_val  = sroot[SQRT_CELLS][30:0];
  assign l2c    = $signed({1'b0, lower_r}) * s_side.c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= sv[SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_k1_r  <= $signed({3'b0, upper_r, 30'b0}) + l2c;
      h_k2_r  <= lower_r * s_val;
      h_s_r   <= s_val;
      h_c_r   <= s_side.c;
      h_x_r   <= s_side.x;
      h_y_r   <= s_side.y;
      h_oor_r <= s_side.oor;
    end
  end

  // three atan2 lanes in lockstep
  logic                 ve, vt, vk;
  logic signed [ZW-1:0] ze, zt, zk;
  logic                 oe, ot, ok;

  ikl_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_elbow (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (h_v_r),
    .x_in      ({{(CW-32){h_c_r[31]}}, h_c_r}),
    .y_in      ({{(CW-31){1'b0}}, h_s_r}),
    .side_in   (h_oor_r),
    .valid_out (ve),
    .z_out     (ze),
    .side_out  (oe)
  );

  ikl_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_target (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (h_v_r),
    .x_in      ({{(CW-30){h_x_r[15]}}, h_x_r, 14'b0}),
    .y_in      ({{(CW-30){h_y_r[15]}}, h_y_r, 14'b0}),
    .side_in   (h_oor_r),
    .valid_out (vt),
    .z_out     (zt),
    .side_out  (ot)
  );

  ikl_cordic #(.STEPS(CORDIC_STEPS), .SW(1)) u_link (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (h_v_r),
    .x_in      ({{(CW-48){h_k1_r[47]}}, h_k1_r}),
    .y_in      ({{(CW-46){1'b0}}, h_k2_r}),
    .side_in   (h_oor_r),
    .valid_out (vk),
    .z_out     (zk),
    .side_out  (ok)
  );

  // output stage: round to 1/128 degree and clamp
  logic signed [ZW:0] base_a;
  logic signed [ZW:0] base_rnd;
  logic signed [ZW:0] base_cl;
  logic signed [ZW:0] elbow_rnd;
  logic signed [ZW:0] elbow_cl;
  logic               oor_f;
  logic               out_valid_r;
  logic signed [16:0] out_base_r;
  logic [14:0]        out_elbow_r;
  logic               out_oor_r;

  assign oor_f     = oe & ot & ok;
  assign base_a    = {zt[ZW-1], zt} - {zk[ZW-1], zk};
  assign base_rnd  = (base_a + ROUND) >>> 9;
  assign elbow_rnd = ($signed({ze[ZW-1], ze}) + ROUND) >>> 9;

  always_comb begin
    if (base_rnd > BASE_HI) begin
      base_cl = BASE_HI;
    end else if (base_rnd < BASE_LO) begin
      base_cl = BASE_LO;
    end else begin
      base_cl = base_rnd;
    end
    if (elbow_rnd > ELBOW_HI) begin
      elbow_cl = ELBOW_HI;
    end else if (elbow_rnd < 0) begin
      elbow_cl = '0;
    end else begin
      elbow_cl = elbow_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ve & vt & vk;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_base_r  <= oor_f ? '0 : base_cl[16:0];
      out_elbow_r <= oor_f ? '0 : elbow_cl[14:0];
      out_oor_r   <= oor_f;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.base_angle   = out_base_r;
  assign out_ch.elbow_angle  = out_elbow_r;
  assign out_ch.out_of_reach = out_oor_r;

  `IKL_ASSERT(a_accept_enters, clk, rst_n, (in_ch.valid && in_ch.ready) |=> a_v_r, "accepted beat lost at pipe entry")
  `IKL_ASSERT(a_lanes_lockstep, clk, rst_n, (ve == vt) && (vt == vk), "atan2 lanes out of step")
  `IKL_ASSERT(a_oor_zero, clk, rst_n, (out_valid_r && out_oor_r) |-> (out_base_r == '0 && out_elbow_r == '0), "angles not zero when out of reach")
  `IKL_ASSERT(a_elbow_range, clk, rst_n, out_valid_r |-> (out_elbow_r <= 15'(ELBOW_LIM)), "elbow angle past clamp")
  `IKL_ASSERT_NR(a_reset_clears, clk, !rst_n |=> !out_valid_r, "output valid survived reset")
endmodule
`default_nettype wire
